@@ sv/owm_pkg.sv @@
`default_nettype none
package owm_pkg;

  // Bits in one byte slot sequence and width of a timing register.
  localparam int BYTE_BITS = 8;
  localparam int CFG_W     = 10;
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_START    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd7;

  typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_regs_t;

  // Values after reset, entry i belongs to register index i.
  localparam cfg_regs_t CFG_RESET_VALS = {
    10'd50, 10'd5, 10'd5, 10'd50, 10'd10, 10'd350, 10'd70, 10'd500
  };

  // Item kinds.
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  // Command codes.
  localparam logic [2:0] OP_RESET = 3'd0;
  localparam logic [2:0] OP_WBIT  = 3'd1;
  localparam logic [2:0] OP_RBIT  = 3'd2;
  localparam logic [2:0] OP_WBYTE = 3'd3;
  localparam logic [2:0] OP_RBYTE = 3'd4;

  // Slot phases.
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_WAIT = 4'd2;
  localparam logic [3:0] PH_RST_TAIL = 4'd3;
  localparam logic [3:0] PH_WR_LOW   = 4'd4;
  localparam logic [3:0] PH_WR_HOLD  = 4'd5;
  localparam logic [3:0] PH_RD_LOW   = 4'd6;
  localparam logic [3:0] PH_RD_WAIT  = 4'd7;
  localparam logic [3:0] PH_RD_TAIL  = 4'd8;

  typedef struct packed {
    logic       kind;
    logic [2:0] op;
    logic [7:0] data;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_level;
    logic [7:0] read_data;
    logic       command_rejected;
  } out_item_t;

endpackage
`default_nettype wire

@@ sv/owm_cfg.sv @@
`default_nettype none
module owm_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [owm_pkg::CFG_W-1:0]      cfg_data,
  output owm_pkg::cfg_regs_t                  regs
);
  import owm_pkg::*;

  // Timing register file, one write per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET_VALS;
    end else if (cfg_write) begin
      regs[cfg_index] <= cfg_data;
    end
  end

endmodule
`default_nettype wire

@@ sv/owm_engine.sv @@
`default_nettype none
module owm_engine #(
  parameter int TIME_WIDTH = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                go,
  input  wire owm_pkg::in_item_t   item,
  input  wire owm_pkg::cfg_regs_t  regs,
  output owm_pkg::out_item_t       result
);
  import owm_pkg::*;

  localparam int CMP_W = ((TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W) + 1;

  logic [3:0]            phase, phase_next;
  logic [TIME_WIDTH-1:0] time_count, time_count_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [2:0]            current_op, current_op_next;
  logic                  presence_reg, presence_reg_next;
  logic [7:0]            received_byte, received_byte_next;

  logic [CFG_W-1:0]      phase_len;
  logic [2:0]            len_idx;
  logic [CMP_W-1:0]      count_plus;
  logic                  phase_end;
  logic                  byte_op;
  logic                  done;
  logic                  rejected;
  logic                  drive;

  // Length of the current phase from the register file.
  assign len_idx    = 3'(phase - 4'd1);
  assign phase_len  = ((phase == PH_IDLE) || (phase > PH_RD_TAIL)) ?
                      CFG_W'(1) : regs[len_idx];
  assign count_plus = CMP_W'(time_count) + CMP_W'(1);
  assign phase_end  = (count_plus >= CMP_W'(phase_len)) || (&time_count);
  assign byte_op    = (current_op == OP_WBYTE) || (current_op == OP_RBYTE);

  // Next state for one item.
  always_comb begin
    phase_next         = phase;
    time_count_next    = time_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    current_op_next    = current_op;
    presence_reg_next  = presence_reg;
    received_byte_next = received_byte;
    done               = 1'b0;
    rejected           = 1'b0;
    if (item.kind == KIND_COMMAND) begin
      if ((phase != PH_IDLE) || (item.op > OP_RBYTE)) begin
        rejected = 1'b1;
      end else begin
        current_op_next = item.op;
        bit_index_next  = 3'd0;
        time_count_next = '0;
        if (item.op == OP_WBYTE) begin
          shift_byte_next = item.data;
        end else if (item.op == OP_WBIT) begin
          shift_byte_next = {7'd0, (item.data != 8'd0)};
        end else begin
          shift_byte_next = 8'd0;
        end
        if (item.op == OP_RESET) begin
          phase_next = PH_RST_LOW;
        end else if ((item.op == OP_WBIT) || (item.op == OP_WBYTE)) begin
          phase_next = PH_WR_LOW;
        end else begin
          phase_next = PH_RD_LOW;
        end
      end
    end else if (phase != PH_IDLE) begin
      if (phase_end) begin
        time_count_next = '0;
        unique case (phase)
          PH_RST_LOW: begin
            phase_next = PH_RST_WAIT;
          end
          PH_RST_WAIT: begin
            presence_reg_next = item.line_level;
            phase_next        = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_WR_LOW: begin
            phase_next = PH_WR_HOLD;
          end
          PH_RD_LOW: begin
            phase_next = PH_RD_WAIT;
          end
          PH_RD_WAIT: begin
            if (item.line_level) begin
              shift_byte_next[bit_index] = 1'b1;
            end
            phase_next = PH_RD_TAIL;
          end
          PH_WR_HOLD, PH_RD_TAIL: begin
            // End of a bit slot: move to the next bit or finish.
            if (byte_op && (bit_index < 3'(BYTE_BITS - 1))) begin
              bit_index_next = bit_index + 3'd1;
              phase_next     = (current_op == OP_WBYTE) ? PH_WR_LOW : PH_RD_LOW;
            end else begin
              if ((current_op == OP_RBIT) || (current_op == OP_RBYTE)) begin
                received_byte_next = shift_byte;
              end
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end else begin
        time_count_next = time_count + TIME_WIDTH'(1);
      end
    end
  end

  // Line drive after this item.
  always_comb begin
    case (phase_next)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = 1'b1;
      PH_WR_HOLD:                       drive = ~shift_byte_next[bit_index_next];
      default:                          drive = 1'b0;
    endcase
  end

  assign result.drive_low        = drive;
  assign result.busy_res         = (phase_next != PH_IDLE);
  assign result.done_res         = done;
  assign result.presence_level   = presence_reg_next;
  assign result.read_data        = received_byte_next;
  assign result.command_rejected = rejected;

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      time_count    <= '0;
      bit_index     <= 3'd0;
      shift_byte    <= 8'd0;
      current_op    <= OP_RESET;
      presence_reg  <= 1'b1;
      received_byte <= 8'd0;
    end else if (go) begin
      phase         <= phase_next;
      time_count    <= time_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      current_op    <= current_op_next;
      presence_reg  <= presence_reg_next;
      received_byte <= received_byte_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/one_wire_bus_master_unit.sv @@
// Channel   Handshake                Payload
// in        in_valid / in_ready      in_item  (kind, op, data, line_level)
// out       out_valid / out_ready    out_item (drive_low .. command_rejected)
// cfg       cfg_write                cfg_index, cfg_data
//
// One item per cycle sustained while results are taken; each accepted item
// passes the input register, then the slot engine into the result register.
// The slot engine updates its state once per item, which sets this rate.
// Synchronous reset restores the timing registers and idles the engine.
// A stalled result holds the engine; the input register still takes one item if it is empty.
`default_nettype none
module one_wire_bus_master_unit #(
  parameter int TIME_WIDTH = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire owm_pkg::in_item_t              in_item,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output owm_pkg::out_item_t                  out_item,
  input  wire logic                           cfg_write,
  input  wire logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [owm_pkg::CFG_W-1:0]      cfg_data
);
  import owm_pkg::*;

  in_item_t  in_q;
  logic      in_q_valid;
  logic      advance;
  logic      go;
  cfg_regs_t regs;
  out_item_t result;

  assign advance  = !out_valid || out_ready;
  assign go       = in_q_valid && advance;
  assign in_ready = !in_q_valid || advance;

  owm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  owm_engine #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (in_q),
    .regs   (regs),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_item <= result;
    end
  end

endmodule
`default_nettype wire
